[rtl/atrk_pkg.sv]
// ----------------------------------------------------------------------------
// atrk_pkg
// Shared types and codes of the allocation tracker table.
// ----------------------------------------------------------------------------
package atrk_pkg;

	localparam int unsigned ADDR_W  = 32;
	localparam int unsigned SIZE_W  = 32;
	localparam int unsigned LIVE_W  = 5;

	typedef enum logic [1:0] {
		CMD_RECORD  = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_REPORT  = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_RECORDED  = 3'd0,
		ST_FULL      = 3'd1,
		ST_RELEASED  = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_LEAK      = 3'd4,
		ST_NO_LEAK   = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_MOVE,
		S_REPORT
	} state_t;

	typedef struct packed {
		cmd_t              command;
		logic [ADDR_W-1:0] block_address;
		logic [SIZE_W-1:0] block_size;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [ADDR_W-1:0] entry_address;
		logic [SIZE_W-1:0] entry_size;
		logic [LIVE_W-1:0] live_count;
		logic              last;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [SIZE_W-1:0] size;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic    load;
		logic    idx_clr;
		logic    idx_inc;
		logic    rd_tail;
		logic    wr_rec;
		logic    wr_move;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    emit;
		status_t status;
		logic    use_entry;
		logic    last;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		cmd_t cmd;
		logic count_zero;
		logic count_full;
		logic match;
		logic idx_last;
	} sts_t;

endpackage

[rtl/atrk_ram.sv]
// ----------------------------------------------------------------------------
// atrk_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module atrk_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/atrk_datapath.sv]
// ----------------------------------------------------------------------------
// atrk_datapath
// Entry RAM, live count, scan index, search compare and result register.
// ----------------------------------------------------------------------------
module atrk_datapath import atrk_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  req_t request,
	input  ctl_t ctl,
	output sts_t sts,
	output logic strobe,
	output rsp_t result
);

	localparam int unsigned IW = $clog2(TABLE_DEPTH);
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

	logic [CW-1:0]     count_q;
	logic [CW-1:0]     count_d;
	logic [IW-1:0]     idx_q;
	logic [IW-1:0]     idx_d;
	logic [ADDR_W-1:0] addr_q;
	logic [IW-1:0]     tail;
	logic [IW-1:0]     raddr;
	logic [IW-1:0]     waddr;
	logic              we;
	entry_t            wdata;
	entry_t            rdata;
	logic [CW+LIVE_W-1:0] live_wide;
	logic              strobe_q;
	rsp_t              result_q;

	assign tail = IW'(count_q - CW'(1));

	always_comb begin
		if (ctl.idx_clr) begin
			idx_d = '0;
		end else if (ctl.idx_inc) begin
			idx_d = idx_q + IW'(1);
		end else begin
			idx_d = idx_q;
		end
	end

	always_comb begin
		if (ctl.cnt_inc) begin
			count_d = count_q + CW'(1);
		end else if (ctl.cnt_dec) begin
			count_d = count_q - CW'(1);
		end else begin
			count_d = count_q;
		end
	end

	// read ahead so the entry at the next index is ready in the next cycle
	assign raddr = ctl.rd_tail ? tail : idx_d;
	assign we    = ctl.wr_rec | ctl.wr_move;
	assign waddr = ctl.wr_rec ? IW'(count_q) : idx_q;

	always_comb begin
		if (ctl.wr_rec) begin
			wdata.addr = request.block_address;
			wdata.size = request.block_size;
		end else begin
			wdata = rdata;
		end
	end

	atrk_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			idx_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			count_q  <= count_d;
			idx_q    <= idx_d;
			strobe_q <= ctl.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			addr_q <= request.block_address;
		end
	end

	assign live_wide = (CW+LIVE_W)'(count_d);

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			result_q.status        <= ctl.status;
			result_q.entry_address <= ctl.use_entry ? rdata.addr : '0;
			result_q.entry_size    <= ctl.use_entry ? rdata.size : '0;
			result_q.live_count    <= live_wide[LIVE_W-1:0];
			result_q.last          <= ctl.last;
		end
	end

	assign sts.cmd        = request.command;
	assign sts.count_zero = (count_q == '0);
	assign sts.count_full = (count_q == CW'(TABLE_DEPTH));
	assign sts.match      = (rdata.addr == addr_q);
	assign sts.idx_last   = ((CW'(idx_q) + CW'(1)) == count_q);

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

[rtl/atrk_ctrl.sv]
// ----------------------------------------------------------------------------
// atrk_ctrl
// Command sequencer: record, release search and move, report walk.
// ----------------------------------------------------------------------------
module atrk_ctrl import atrk_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output logic busy,
	output ctl_t ctl
);

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (sts.cmd == CMD_RELEASE && !sts.count_zero) begin
						state_d = S_SEARCH;
					end else if (sts.cmd == CMD_REPORT && !sts.count_zero) begin
						state_d = S_REPORT;
					end
				end
			end
			S_SEARCH: begin
				if (sts.match) begin
					state_d = S_MOVE;
				end else if (sts.idx_last) begin
					state_d = S_IDLE;
				end
			end
			S_MOVE: begin
				state_d = S_IDLE;
			end
			S_REPORT: begin
				if (sts.idx_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl        = '0;
		ctl.status = ST_RECORDED;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.load    = 1'b1;
					ctl.idx_clr = 1'b1;
					case (sts.cmd)
						CMD_RECORD: begin
							ctl.emit = 1'b1;
							ctl.last = 1'b1;
							if (sts.count_full) begin
								ctl.status = ST_FULL;
							end else begin
								ctl.wr_rec  = 1'b1;
								ctl.cnt_inc = 1'b1;
								ctl.status  = ST_RECORDED;
							end
						end
						CMD_RELEASE: begin
							if (sts.count_zero) begin
								ctl.emit   = 1'b1;
								ctl.last   = 1'b1;
								ctl.status = ST_NOT_FOUND;
							end
						end
						CMD_REPORT: begin
							if (sts.count_zero) begin
								ctl.emit   = 1'b1;
								ctl.last   = 1'b1;
								ctl.status = ST_NO_LEAK;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_SEARCH: begin
				if (sts.match) begin
					ctl.rd_tail = 1'b1;
				end else if (sts.idx_last) begin
					ctl.emit   = 1'b1;
					ctl.last   = 1'b1;
					ctl.status = ST_NOT_FOUND;
				end else begin
					ctl.idx_inc = 1'b1;
				end
			end
			S_MOVE: begin
				ctl.wr_move = 1'b1;
				ctl.cnt_dec = 1'b1;
				ctl.emit    = 1'b1;
				ctl.last    = 1'b1;
				ctl.status  = ST_RELEASED;
			end
			S_REPORT: begin
				ctl.emit      = 1'b1;
				ctl.use_entry = 1'b1;
				ctl.last      = sts.idx_last;
				ctl.status    = ST_LEAK;
				ctl.idx_inc   = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

[rtl/allocation_tracker_table.sv]
// ----------------------------------------------------------------------------
// allocation_tracker_table
// Compact table of outstanding allocations with record, release and report.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; every result appears
// for one cycle with strobe high, and the last result of a request has last
// set. Record, a full table, and release or report on an empty table never
// raise busy: the result comes the cycle after the request. A release scans
// the live entries one per cycle through the single read port of the entry
// RAM, and on a match moves the tail entry into the matched slot before it
// ends. A report streams one leak result per live entry, one per cycle, back
// to back. Results cannot be held off.
module allocation_tracker_table import atrk_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t request,
	output logic strobe,
	output rsp_t result
);

	ctl_t ctl;
	sts_t sts;

	atrk_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.sts   (sts),
		.busy  (busy),
		.ctl   (ctl)
	);

	atrk_datapath #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.request(request),
		.ctl    (ctl),
		.sts    (sts),
		.strobe (strobe),
		.result (result)
	);

	// a result only follows an accepted request or a busy cycle
	a_strobe_cause: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> ($past(start) && !$past(busy)) || $past(busy))
		else $error("result without request");

	// report results come back to back until the last one
	a_stream: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |=> strobe)
		else $error("gap in report stream");

	// the block is idle once the last result shows
	a_idle_at_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last |-> !busy)
		else $error("busy after last result");

	// non-leak results are single with zero entry fields
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.status != ST_LEAK |->
			result.last && result.entry_address == '0 && result.entry_size == '0)
		else $error("malformed single result");

endmodule
